[design/bai_pkg.sv]
// Shared types and constants for the barycentric attribute interpolator.
// No dependencies; every other design file imports this package.
package bai_pkg;

    localparam int PIXEL_BITS_DEF    = 12;
    localparam int TEX_FRAC_BITS_DEF = 8;

    localparam int TEX_W       = 24;
    localparam int POS_W       = 32;
    localparam int NORM_W      = 16;
    localparam int SLOT_W      = 2;
    localparam int NUM_CORNERS = 3;
    localparam int NUM_AXES    = 3;

    localparam int INV_W     = 32;
    localparam int WGT_W     = 32;
    localparam int WGT_FRAC  = 24;
    localparam int WGT_GUARD = 6;

    localparam int DIFF_W    = TEX_W + 1;
    localparam int AREA_W    = 2 * DIFF_W + 1;
    localparam int SHIFT_W   = $clog2(AREA_W + 1);
    localparam int DIV_CNT_W = $clog2(INV_W);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DIFF,
        SEQ_MUL,
        SEQ_SUM,
        SEQ_NORM,
        SEQ_DIV
    } seq_state_t;

endpackage

[design/bai_in_if.sv]
// Input channel: vertex-load and pixel words with valid/ready.
// Depends on bai_pkg.
interface bai_in_if #(
    parameter int PIXEL_BITS = bai_pkg::PIXEL_BITS_DEF
);
    import bai_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SLOT_W-1:0]        vertex_slot;
    logic signed [TEX_W-1:0]  tex_u;
    logic signed [TEX_W-1:0]  tex_v;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [PIXEL_BITS-1:0]    pixel_x;
    logic [PIXEL_BITS-1:0]    pixel_y;

    modport source (
        output valid, mode, vertex_slot, tex_u, tex_v, pos_x, pos_y, pos_z,
               norm_x, norm_y, norm_z, pixel_x, pixel_y,
        input  ready
    );

    modport sink (
        input  valid, mode, vertex_slot, tex_u, tex_v, pos_x, pos_y, pos_z,
               norm_x, norm_y, norm_z, pixel_x, pixel_y,
        output ready
    );

endinterface

[design/bai_out_if.sv]
// Result channel: interpolated attributes and flags with valid/ready.
// Depends on bai_pkg.
interface bai_out_if;
    import bai_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     inside_res;
    logic                     degenerate;
    logic signed [POS_W-1:0]  out_pos_x;
    logic signed [POS_W-1:0]  out_pos_y;
    logic signed [POS_W-1:0]  out_pos_z;
    logic signed [NORM_W-1:0] out_norm_x;
    logic signed [NORM_W-1:0] out_norm_y;
    logic signed [NORM_W-1:0] out_norm_z;

    modport source (
        output valid, inside_res, degenerate, out_pos_x, out_pos_y, out_pos_z,
               out_norm_x, out_norm_y, out_norm_z,
        input  ready
    );

    modport sink (
        input  valid, inside_res, degenerate, out_pos_x, out_pos_y, out_pos_z,
               out_norm_x, out_norm_y, out_norm_z,
        output ready
    );

endinterface

[design/barycentric_attribute_interpolator_core.sv]
// Barycentric attribute interpolator: 9-stage pixel pipeline from an accepted pixel
// word to its result word, one pixel per cycle sustained while res_out is ready and
// no load is in progress. A vertex load waits for stages 0-7 to drain, then runs
// the area sequencer: setup (differences, products, sum), bit-length count
// (|D| < 2^48) and restoring division (the last two skipped for a zero area), blocking input.
// Reset (rst_n, async low): corners zero, triangle marked degenerate, pipe empty.
module barycentric_attribute_interpolator_core #(
    parameter int PIXEL_BITS    = bai_pkg::PIXEL_BITS_DEF,
    parameter int TEX_FRAC_BITS = bai_pkg::TEX_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bai_in_if.sink     pix_in,
    bai_out_if.source  res_out
);
    import bai_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int PX_W       = PIXEL_BITS + TEX_FRAC_BITS;
    localparam int DX_W       = ((PX_W > TEX_W) ? PX_W : TEX_W) + 2;
    localparam int NPROD_W    = DIFF_W + DX_W;
    localparam int NW         = NPROD_W + 2;          // numerator width
    localparam int AH_W       = NW - INV_W;
    localparam int P_W        = NW + INV_W;           // |N| * inverse
    localparam int KSH_W      = SHIFT_W + 1;
    localparam int NSTG       = 9;
    localparam int PPROD_W    = WGT_W + POS_W;
    localparam int NPROD2_W   = WGT_W + NORM_W;
    localparam int PSUM_W     = PPROD_W + 2;
    localparam int NSUM_W     = NPROD2_W + 2;
    localparam int PRES_W     = PSUM_W - WGT_FRAC;
    localparam int NRES_W     = NSUM_W - WGT_FRAC;
    localparam int MAG_W      = WGT_W - 1;

    // ------------------------------------------------------------------
    // Triangle state
    // ------------------------------------------------------------------
    logic signed [TEX_W-1:0]  tex_u_reg [NUM_CORNERS];
    logic signed [TEX_W-1:0]  tex_v_reg [NUM_CORNERS];
    logic signed [POS_W-1:0]  pos_reg   [NUM_CORNERS][NUM_AXES];
    logic signed [NORM_W-1:0] norm_reg  [NUM_CORNERS][NUM_AXES];

    // Edge coefficients shared by the area setup and the pixel pipe
    logic signed [DIFF_W-1:0]   a0_reg, b0_reg, a1_reg, b1_reg;
    logic signed [2*DIFF_W-1:0] dp0_reg, dp1_reg;
    logic signed [AREA_W-1:0]   d_reg;
    logic [AREA_W-1:0]          dabs_reg;
    logic                       area_neg_reg;
    logic                       zero_area_reg;
    logic [INV_W-1:0]           inv_reg;
    logic [SHIFT_W-1:0]         area_shift_reg;

    // Sequencer
    seq_state_t              seq_state_reg, seq_state_next;
    logic [AREA_W-1:0]       norm_t_reg;
    logic [SHIFT_W-1:0]      norm_n_reg;
    logic [AREA_W:0]         rem_reg;
    logic [INV_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [AREA_W:0]         div_r;
    logic                    div_ge;
    logic [AREA_W:0]         div_rem_next;
    logic signed [AREA_W-1:0] d_sum;

    // Handshake
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;
    logic            pipe_busy;
    logic            accept;
    logic            px_acc;
    logic            ld_acc;

    // ------------------------------------------------------------------
    // Input handshake. Pixels stream in whenever stage 0 can move; a load
    // additionally needs the pipe empty so in-flight pixels keep the old
    // triangle. Nothing enters while the area sequencer runs.
    // ------------------------------------------------------------------
    assign pipe_busy    = |vld_reg[NSTG-2:0];
    assign pix_in.ready = en[0] && (seq_state_reg == SEQ_IDLE) &&
                          ((pix_in.mode == MODE_PIXEL) || !pipe_busy);
    assign accept = pix_in.valid && pix_in.ready;
    assign px_acc = accept && (pix_in.mode == MODE_PIXEL);
    assign ld_acc = accept && (pix_in.mode == MODE_LOAD) &&
                    (pix_in.vertex_slot < SLOT_W'(NUM_CORNERS));

    // Stage enables: a stage moves when empty or when its successor moves.
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || res_out.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= px_acc;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Corner store
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                tex_u_reg[c] <= '0;
                tex_v_reg[c] <= '0;
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    pos_reg[c][j]  <= '0;
                    norm_reg[c][j] <= '0;
                end
            end
        end
        else if (ld_acc)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                if (pix_in.vertex_slot == SLOT_W'(c))
                begin
                    tex_u_reg[c]   <= pix_in.tex_u;
                    tex_v_reg[c]   <= pix_in.tex_v;
                    pos_reg[c][0]  <= pix_in.pos_x;
                    pos_reg[c][1]  <= pix_in.pos_y;
                    pos_reg[c][2]  <= pix_in.pos_z;
                    norm_reg[c][0] <= pix_in.norm_x;
                    norm_reg[c][1] <= pix_in.norm_y;
                    norm_reg[c][2] <= pix_in.norm_z;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Area sequencer: edge terms, D, bit length n of |D|, then
    // inverse = floor(2^(n+30) / |D|) one quotient bit per cycle; a zero D skips n and inverse.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_IDLE;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
        end
    end

    always_comb
    begin
        seq_state_next = seq_state_reg;
        d_sum  = AREA_W'(dp0_reg) - AREA_W'(dp1_reg);
        div_r  = (div_cnt_reg == '0) ? rem_reg : {rem_reg[AREA_W-1:0], 1'b0};
        div_ge = (div_r >= {1'b0, dabs_reg});
        div_rem_next = div_ge ? (div_r - {1'b0, dabs_reg}) : div_r;
        unique case (seq_state_reg)
            SEQ_IDLE: if (ld_acc) seq_state_next = SEQ_DIFF;
            SEQ_DIFF: seq_state_next = SEQ_MUL;
            SEQ_MUL:  seq_state_next = SEQ_SUM;
            SEQ_SUM:  seq_state_next = (d_sum == '0) ? SEQ_IDLE : SEQ_NORM;
            SEQ_NORM: if (norm_t_reg == '0) seq_state_next = SEQ_DIV;
            SEQ_DIV:  if (div_cnt_reg == DIV_CNT_W'(INV_W - 1)) seq_state_next = SEQ_IDLE;
            default:  seq_state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg         <= '0;
            b0_reg         <= '0;
            a1_reg         <= '0;
            b1_reg         <= '0;
            dp0_reg        <= '0;
            dp1_reg        <= '0;
            d_reg          <= '0;
            dabs_reg       <= '0;
            area_neg_reg   <= 1'b0;
            zero_area_reg  <= 1'b1;
            inv_reg        <= '0;
            area_shift_reg <= '0;
            norm_t_reg     <= '0;
            norm_n_reg     <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            case (seq_state_reg)
                SEQ_DIFF:
                begin
                    a0_reg <= DIFF_W'(tex_v_reg[1]) - DIFF_W'(tex_v_reg[2]);
                    b0_reg <= DIFF_W'(tex_u_reg[2]) - DIFF_W'(tex_u_reg[1]);
                    a1_reg <= DIFF_W'(tex_v_reg[2]) - DIFF_W'(tex_v_reg[0]);
                    b1_reg <= DIFF_W'(tex_u_reg[0]) - DIFF_W'(tex_u_reg[2]);
                end
                SEQ_MUL:
                begin
                    // D = a0*b1 + b0*(y0-y2) = a0*b1 - b0*a1
                    dp0_reg <= a0_reg * b1_reg;
                    dp1_reg <= b0_reg * a1_reg;
                end
                SEQ_SUM:
                begin
                    d_reg         <= d_sum;
                    zero_area_reg <= (d_sum == '0);
                    area_neg_reg  <= d_sum[AREA_W-1];
                    dabs_reg      <= d_sum[AREA_W-1] ? AREA_W'(-d_sum) : AREA_W'(d_sum);
                    norm_t_reg    <= d_sum[AREA_W-1] ? AREA_W'(-d_sum) : AREA_W'(d_sum);
                    norm_n_reg    <= '0;
                    if (d_sum == '0)
                    begin
                        inv_reg        <= '0;
                        area_shift_reg <= '0;
                    end
                end
                SEQ_NORM:
                begin
                    if (norm_t_reg != '0)
                    begin
                        norm_t_reg <= norm_t_reg >> 1;
                        norm_n_reg <= norm_n_reg + 1'b1;
                    end
                    else
                    begin
                        rem_reg     <= (AREA_W + 1)'(1) << (norm_n_reg - 1'b1);
                        quo_reg     <= '0;
                        div_cnt_reg <= '0;
                    end
                end
                SEQ_DIV:
                begin
                    rem_reg     <= div_rem_next;
                    quo_reg     <= {quo_reg[INV_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(INV_W - 1))
                    begin
                        inv_reg        <= {quo_reg[INV_W-2:0], div_ge};
                        area_shift_reg <= norm_n_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pixel pipeline
    // s0 pixel offsets, s1 edge products, s2 numerators, s3 sign/magnitude,
    // s4 split multiply by inverse, s5 merge, s6 shift+saturate to Q7.24,
    // s7 weight*attribute products, s8 sum, scale, saturate (output word).
    // ------------------------------------------------------------------
    logic signed [DX_W-1:0]    px_s, py_s;
    logic signed [DX_W-1:0]    dx0_reg, dy0_reg;
    logic signed [NPROD_W-1:0] m_reg [4];
    logic signed [NW-1:0]      n_reg [NUM_CORNERS];
    logic [NW-1:0]             mag_reg [NUM_CORNERS];
    logic [NUM_CORNERS-1:0]    wneg3_reg, wneg4_reg, wneg5_reg;
    logic [2*INV_W-1:0]        lo_reg [NUM_CORNERS];
    logic [NW-1:0]             hp_reg [NUM_CORNERS];
    logic [P_W-1:0]            p_reg [NUM_CORNERS];
    logic signed [WGT_W-1:0]   w_reg [NUM_CORNERS];
    logic signed [PPROD_W-1:0]  pprod_reg [NUM_CORNERS][NUM_AXES];
    logic signed [NPROD2_W-1:0] nprod_reg [NUM_CORNERS][NUM_AXES];
    logic [NSTG-2:0]           deg_reg;
    logic [NSTG-2:3]           ins_reg;
    logic [KSH_W-1:0]          ksh;

    logic                     out_inside_reg, out_degen_reg;
    logic signed [POS_W-1:0]  out_pos_reg  [NUM_AXES];
    logic signed [NORM_W-1:0] out_norm_reg [NUM_AXES];

    assign px_s = DX_W'(pix_in.pixel_x) << TEX_FRAC_BITS;
    assign py_s = DX_W'(pix_in.pixel_y) << TEX_FRAC_BITS;
    assign ksh  = KSH_W'(area_shift_reg) + KSH_W'(WGT_GUARD);

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PRES_W-1:0] v);
        logic [PRES_W-POS_W:0] top;
        top = v[PRES_W-1:POS_W-1];
        if ((top == '0) || (top == '1))
            return v[POS_W-1:0];
        return v[PRES_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [NRES_W-1:0] v);
        logic [NRES_W-NORM_W:0] top;
        top = v[NRES_W-1:NORM_W-1];
        if ((top == '0) || (top == '1))
            return v[NORM_W-1:0];
        return v[NRES_W-1] ? {1'b1, {(NORM_W-1){1'b0}}} : {1'b0, {(NORM_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk)
    begin
        // s0
        if (en[0])
        begin
            dx0_reg    <= px_s - DX_W'(tex_u_reg[2]);
            dy0_reg    <= py_s - DX_W'(tex_v_reg[2]);
            deg_reg[0] <= zero_area_reg;
        end
        // s1
        if (en[1])
        begin
            m_reg[0]   <= a0_reg * dx0_reg;
            m_reg[1]   <= b0_reg * dy0_reg;
            m_reg[2]   <= a1_reg * dx0_reg;
            m_reg[3]   <= b1_reg * dy0_reg;
            deg_reg[1] <= deg_reg[0];
        end
        // s2: gamma numerator is D - Na - Nb exactly
        if (en[2])
        begin
            n_reg[0]   <= NW'(m_reg[0]) + NW'(m_reg[1]);
            n_reg[1]   <= NW'(m_reg[2]) + NW'(m_reg[3]);
            n_reg[2]   <= NW'(d_reg) - (NW'(m_reg[0]) + NW'(m_reg[1]))
                                     - (NW'(m_reg[2]) + NW'(m_reg[3]));
            deg_reg[2] <= deg_reg[1];
        end
        // s3
        if (en[3])
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                mag_reg[i]   <= n_reg[i][NW-1] ? NW'(-n_reg[i]) : NW'(n_reg[i]);
                wneg3_reg[i] <= n_reg[i][NW-1] ^ area_neg_reg;
            end
            ins_reg[3] <= ((n_reg[0] == '0) || (n_reg[0][NW-1] == area_neg_reg)) &&
                          ((n_reg[1] == '0) || (n_reg[1][NW-1] == area_neg_reg)) &&
                          ((n_reg[2] == '0) || (n_reg[2][NW-1] == area_neg_reg));
            deg_reg[3] <= deg_reg[2];
        end
        // s4
        if (en[4])
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                lo_reg[i] <= mag_reg[i][INV_W-1:0] * inv_reg;
                hp_reg[i] <= mag_reg[i][NW-1:INV_W] * inv_reg;
            end
            wneg4_reg  <= wneg3_reg;
            ins_reg[4] <= ins_reg[3];
            deg_reg[4] <= deg_reg[3];
        end
        // s5
        if (en[5])
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                p_reg[i] <= (P_W'(hp_reg[i]) << INV_W) + P_W'(lo_reg[i]);
            end
            wneg5_reg  <= wneg4_reg;
            ins_reg[5] <= ins_reg[4];
            deg_reg[5] <= deg_reg[4];
        end
        // s6: |w| = min(P >> (n+6), 2^31-1), truncated toward zero
        if (en[6])
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                logic [P_W-1:0]   sh;
                logic [MAG_W-1:0] m;
                sh = p_reg[i] >> ksh;
                m  = (sh[P_W-1:MAG_W] != '0) ? '1 : sh[MAG_W-1:0];
                w_reg[i] <= wneg5_reg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
            end
            ins_reg[6] <= ins_reg[5];
            deg_reg[6] <= deg_reg[5];
        end
        // s7
        if (en[7])
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    pprod_reg[i][j] <= w_reg[i] * pos_reg[i][j];
                    nprod_reg[i][j] <= w_reg[i] * norm_reg[i][j];
                end
            end
            ins_reg[7] <= ins_reg[6];
            deg_reg[7] <= deg_reg[6];
        end
        // s8: floor(sum / 2^24), saturate; degenerate answers all zero
        if (en[8])
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                logic signed [PSUM_W-1:0] ps;
                logic signed [NSUM_W-1:0] ns;
                ps = PSUM_W'(pprod_reg[0][j]) + PSUM_W'(pprod_reg[1][j]) +
                     PSUM_W'(pprod_reg[2][j]);
                ns = NSUM_W'(nprod_reg[0][j]) + NSUM_W'(nprod_reg[1][j]) +
                     NSUM_W'(nprod_reg[2][j]);
                out_pos_reg[j]  <= deg_reg[7] ? '0 : sat_pos(ps[PSUM_W-1:WGT_FRAC]);
                out_norm_reg[j] <= deg_reg[7] ? '0 : sat_norm(ns[NSUM_W-1:WGT_FRAC]);
            end
            out_inside_reg <= ins_reg[7] && !deg_reg[7];
            out_degen_reg  <= deg_reg[7];
        end
    end

    assign res_out.valid      = vld_reg[NSTG-1];
    assign res_out.inside_res = out_inside_reg;
    assign res_out.degenerate = out_degen_reg;
    assign res_out.out_pos_x  = out_pos_reg[0];
    assign res_out.out_pos_y  = out_pos_reg[1];
    assign res_out.out_pos_z  = out_pos_reg[2];
    assign res_out.out_norm_x = out_norm_reg[0];
    assign res_out.out_norm_y = out_norm_reg[1];
    assign res_out.out_norm_z = out_norm_reg[2];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Triangle state may only change with no pixel in flight.
    a_seq_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg != SEQ_IDLE) |-> (vld_reg[NSTG-2:0] == '0))
        else $error("area sequencer running with pixels in flight");

    // A valid load starts the area setup on the next cycle.
    a_load_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready && (pix_in.mode == MODE_LOAD) &&
         (pix_in.vertex_slot < SLOT_W'(NUM_CORNERS))) |=> (seq_state_reg == SEQ_DIFF))
        else $error("vertex load did not start area setup");

    // Degenerate results are never inside and carry zero attributes.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.degenerate) |->
            (!res_out.inside_res && (res_out.out_pos_x == '0) &&
             (res_out.out_norm_z == '0)))
        else $error("degenerate word with nonzero payload");

endmodule
